@@ rtl/nkrt_pkg.sv @@
// Package for the name keyed record table: sizes, codes, shared structs and
// the name normalising function. Used by every module of the block.
// Depends on nothing.
package nkrt_pkg;

   // Table sizing
   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int WORD_W      = 64;
   localparam int WORD3_W     = 56;
   localparam int NAME_BYTES  = 32;
   localparam int NAME_W      = NAME_BYTES * 8;
   localparam int ID_W        = 31;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_CNT_W = 7;

   // Stream word widths, padded to whole bytes
   localparam int REQ_BITS    = ACTION_W + 3 * WORD_W + WORD3_W + ID_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = STATUS_W + ID_W + ENTRY_CNT_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_LOOKUP = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Request as taken from the input stream
   typedef struct packed {
      action_type         action;
      logic [NAME_W-1:0]  name;
      logic [ID_W-1:0]    root_id;
   } req_type;

   // Result handed to the output register
   typedef struct packed {
      status_type             status;
      logic [ID_W-1:0]        found_root_id;
      logic [ENTRY_CNT_W-1:0] entry_count;
   } res_type;

   // Record store ports
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic              name_en;
      logic              id_en;
      logic [IDX_W-1:0]  addr;
      logic [NAME_W-1:0] name;
      logic [ID_W-1:0]   id;
   } wr_req_type;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [ID_W-1:0]   id;
   } rec_type;

   // Zero every byte after the first zero byte of the name
   function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_W-1:0] raw);
      logic              ended;
      logic [7:0]        b;
      logic [NAME_W-1:0] res;
      ended = 1'b0;
      res   = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         b = raw[8*i +: 8];
         if (ended) begin
            b = 8'h00;
         end else if (b == 8'h00) begin
            ended = 1'b1;
         end
         res[8*i +: 8] = b;
      end
      return res;
   endfunction

endpackage

@@ rtl/nkrt_store.sv @@
// Record store: name and identifier memories, one write port and one
// registered read port. Depends on nkrt_pkg.
module nkrt_store
   import nkrt_pkg::*;
(
   input  logic       clock,
   input  rd_req_type rd,
   input  wr_req_type wr,
   output rec_type    rd_data
);

   logic [NAME_W-1:0] name_mem [MAX_ENTRIES];
   logic [ID_W-1:0]   id_mem   [MAX_ENTRIES];
   rec_type           rd_data_ff;

   // Write name row and identifier separately
   always_ff @(posedge clock) begin
      if (wr.name_en) begin
         name_mem[wr.addr] <= wr.name;
      end
      if (wr.id_en) begin
         id_mem[wr.addr] <= wr.id;
      end
   end

   // Registered read of one whole record
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff.name <= name_mem[rd.addr];
         rd_data_ff.id   <= id_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nkrt_seq.sv @@
// Sequencer with the shared record compare: searches, inserts, updates and
// shifts records through the store one row a cycle. Depends on nkrt_pkg.
module nkrt_seq
   import nkrt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_req,
   output logic       res_valid,
   input  logic       res_ready,
   output res_type    res,
   output rd_req_type rd,
   output wr_req_type wr,
   input  rec_type    rd_data
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SEARCH = 4'b0010,
      S_SHIFT  = 4'b0100,
      S_DONE   = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [NAME_W-1:0] name_ff, name_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic              pend_v_ff, pend_v_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   status_type        status_ff, status_in;
   logic [ID_W-1:0]   found_ff, found_in;

   logic match;
   logic hit;
   logic search_end;
   logic more;

   // Shared compare of the returned row against the request name
   assign match      = (rd_data.name == name_ff);
   assign hit        = pend_v_ff && match;
   assign more       = (ptr_ff < count_ff);
   assign search_end = hit || (!pend_v_ff && !more);

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      name_in     = name_ff;
      id_in       = id_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      rd          = '0;
      wr          = '0;
      res_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Take a word and start the scan at record zero
            if (in_valid) begin
               act_in    = in_req.action;
               name_in   = norm_name(in_req.name);
               id_in     = in_req.root_id;
               ptr_in    = '0;
               pend_v_in = 1'b0;
               state_in  = S_SEARCH;
            end
         end

         S_SEARCH: begin
            if (search_end) begin
               status_in = ST_OK;
               found_in  = '0;
               state_in  = S_DONE;
               unique case (act_ff)
                  ACT_INSERT: begin
                     if (hit) begin
                        status_in = ST_DUPLICATE;
                     end else if (count_ff >= CNT_W'(MAX_ENTRIES)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr.name_en = 1'b1;
                        wr.id_en   = 1'b1;
                        wr.addr    = count_ff[IDX_W-1:0];
                        wr.name    = name_ff;
                        wr.id      = id_ff;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  ACT_DELETE: begin
                     if (!hit) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        // Move later records down, starting one above the match
                        ptr_in    = CNT_W'(pend_idx_ff) + 1'b1;
                        pend_v_in = 1'b0;
                        state_in  = S_SHIFT;
                     end
                  end
                  ACT_UPDATE: begin
                     if (!hit) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        wr.id_en = 1'b1;
                        wr.addr  = pend_idx_ff;
                        wr.id    = id_ff;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (!hit) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        found_in = rd_data.id;
                     end
                  end
               endcase
            end else begin
               // Issue the next row while the previous one is compared
               pend_v_in = more;
               if (more) begin
                  rd.en       = 1'b1;
                  rd.addr     = ptr_ff[IDX_W-1:0];
                  pend_idx_in = ptr_ff[IDX_W-1:0];
                  ptr_in      = ptr_ff + 1'b1;
               end
            end
         end

         S_SHIFT: begin
            // Write the row read last cycle one place lower
            if (pend_v_ff) begin
               wr.name_en = 1'b1;
               wr.id_en   = 1'b1;
               wr.addr    = pend_idx_ff - 1'b1;
               wr.name    = rd_data.name;
               wr.id      = rd_data.id;
            end
            pend_v_in = more;
            if (more) begin
               rd.en       = 1'b1;
               rd.addr     = ptr_ff[IDX_W-1:0];
               pend_idx_in = ptr_ff[IDX_W-1:0];
               ptr_in      = ptr_ff + 1'b1;
            end else if (!pend_v_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // Hold the result until the output register takes it
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      name_ff     <= name_in;
      id_ff       <= id_in;
      ptr_ff      <= ptr_in;
      pend_idx_ff <= pend_idx_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
   end

   assign in_ready          = (state_ff == S_IDLE);
   assign res.status        = status_ff;
   assign res.found_root_id = found_ff;
   assign res.entry_count   = ENTRY_CNT_W'(count_ff);

`ifndef NO_ASSERTIONS
   ap_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("record count above table size");

   ap_wr_in_table: assert property (@(posedge clock) disable iff (reset)
      wr.name_en |-> (CNT_W'(wr.addr) <= count_ff))
      else $error("name row written beyond the table end");

   ap_shift_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && state_in == S_DONE) |=>
      (count_ff == $past(count_ff) - 1'b1))
      else $error("delete did not drop the count by one");

   ap_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_ready) |=> (state_ff == S_DONE))
      else $error("result dropped before it was taken");

   ap_lookup_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && act_ff == ACT_LOOKUP) |-> (!wr.name_en && !wr.id_en))
      else $error("lookup wrote the store");
`endif

endmodule

@@ rtl/name_keyed_record_table.sv @@
// Name keyed record table top level: stream ports, sequencer, store, output register.
// A request scans the records from index zero until it finds the name or reaches the count;
// a delete scans to its match then moves each later record down one place.
// A new word is taken only after the last result is handed to the output register.
// The single read port of the record store sets the pace: one row a cycle.
// Reset clears the record count and control state; the memories are not cleared.
module name_keyed_record_table
   import nkrt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // action, name_word0, name_word1, name_word2, name_word3, root_id, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, found_root_id, entry_count, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int W0_LO = ACTION_W;
   localparam int W1_LO = W0_LO + WORD_W;
   localparam int W2_LO = W1_LO + WORD_W;
   localparam int W3_LO = W2_LO + WORD_W;
   localparam int ID_LO = W3_LO + WORD3_W;

   req_type    in_req;
   res_type    res;
   logic       res_valid;
   logic       res_ready;
   rd_req_type rd;
   wr_req_type wr;
   rec_type    rd_data;

   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_res_ff, rsp_res_in;

   // Unpack the request word; byte 31 of the name is always zero
   assign in_req.action  = action_type'(req_tdata[ACTION_W-1:0]);
   assign in_req.name    = {8'h00,
                            req_tdata[W3_LO +: WORD3_W],
                            req_tdata[W2_LO +: WORD_W],
                            req_tdata[W1_LO +: WORD_W],
                            req_tdata[W0_LO +: WORD_W]};
   assign in_req.root_id = req_tdata[ID_LO +: ID_W];

   nkrt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (in_req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .rd        (rd),
      .wr        (wr),
      .rd_data   (rd_data)
   );

   nkrt_store u_store (
      .clock   (clock),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   // Pack the result word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_res_ff.entry_count,
                                    rsp_res_ff.found_root_id,
                                    rsp_res_ff.status});

endmodule

@@ verif/tb_name_keyed_record_table.sv @@
// Testbench for the name keyed record table: a queue-fed stream driver, a
// result monitor checking against an in-bench table predictor, and a watchdog.
// Depends on nkrt_pkg and name_keyed_record_table.
`timescale 1ns / 100ps

module tb_name_keyed_record_table;
   import nkrt_pkg::*;

   localparam int NAME_FIELD_W = 3 * WORD_W + WORD3_W;
   localparam int POOL_SIZE    = 80;
   localparam int HOLD_CYCLES  = 600;
   localparam int STUCK_LIMIT  = 20000;
   localparam int RAND_ITEMS   = 230;
   localparam logic [ID_W-1:0] ID_MAX = '1;

   typedef struct {
      action_type        action;
      logic [NAME_W-1:0] name;
      logic [ID_W-1:0]   root_id;
   } table_req;

   typedef struct {
      status_type             status;
      logic [ID_W-1:0]        found_id;
      logic [ENTRY_CNT_W-1:0] count;
   } table_rsp;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predicted table contents
   logic [NAME_W-1:0] rec_names[MAX_ENTRIES];
   logic [ID_W-1:0]   rec_ids[MAX_ENTRIES];
   int                rec_count;

   table_req req_backlog[$];
   table_rsp rsp_expected[$];
   table_req cur_req;
   int       n_queued;
   int       n_accepted;
   int       fail_count;
   int       send_idle_pct;
   int       stall_pct;
   int       hold_req;
   int       hold_seen;
   int       hold_left;
   int       stuck_cycles;

   logic [NAME_W-1:0] name_pool[POOL_SIZE];
   int                pool_len[POOL_SIZE];

   name_keyed_record_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Clear every byte after the first zero byte
   function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      bit                ended;
      res   = '0;
      ended = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         if (!ended) begin
            res[8*i +: 8] = raw[8*i +: 8];
            if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
         end
      end
      return res;
   endfunction

   // Apply one request to the predicted table and return its result
   function automatic table_rsp apply_request(input table_req r);
      table_rsp          res;
      logic [NAME_W-1:0] key;
      int                idx;
      key          = trim_name(r.name);
      res.status   = ST_OK;
      res.found_id = '0;
      idx          = rec_count;
      for (int k = rec_count - 1; k >= 0; k--) begin
         if (rec_names[k] == key) idx = k;
      end
      if (r.action == ACT_INSERT) begin
         if (idx < rec_count) begin
            res.status = ST_DUPLICATE;
         end else if (rec_count >= MAX_ENTRIES) begin
            res.status = ST_FULL;
         end else begin
            rec_names[rec_count] = key;
            rec_ids[rec_count]   = r.root_id;
            rec_count++;
         end
      end else if (idx >= rec_count) begin
         res.status = ST_NOT_FOUND;
      end else if (r.action == ACT_DELETE) begin
         for (int k = idx; k + 1 < rec_count; k++) begin
            rec_names[k] = rec_names[k+1];
            rec_ids[k]   = rec_ids[k+1];
         end
         rec_count--;
      end else if (r.action == ACT_UPDATE) begin
         rec_ids[idx] = r.root_id;
      end else begin
         res.found_id = rec_ids[idx];
      end
      res.count = rec_count[ENTRY_CNT_W-1:0];
      return res;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_req(input table_req r);
      logic [REQ_DATA_W-1:0] w;
      w = '0;
      w[0 +: ACTION_W]                       = r.action;
      w[ACTION_W +: NAME_FIELD_W]            = r.name[NAME_FIELD_W-1:0];
      w[ACTION_W + NAME_FIELD_W +: ID_W]     = r.root_id;
      return w;
   endfunction

   // Pool name, optionally with junk after its terminator
   function automatic logic [NAME_W-1:0] pool_name(input int idx, input bit junk);
      logic [NAME_W-1:0] n;
      n = name_pool[idx];
      if (junk) begin
         for (int b = pool_len[idx] + 1; b < NAME_BYTES - 1; b++) begin
            n[8*b +: 8] = 8'($urandom);
         end
      end
      return n;
   endfunction

   // Raw random bytes, zeros allowed anywhere
   function automatic logic [NAME_W-1:0] noise_name();
      logic [NAME_W-1:0] n;
      n = '0;
      for (int b = 0; b < NAME_BYTES - 1; b++) begin
         n[8*b +: 8] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
      end
      return n;
   endfunction

   task automatic queue_req(input action_type a, input logic [NAME_W-1:0] n,
                            input logic [ID_W-1:0] id);
      table_req r;
      r.action  = a;
      r.name    = n;
      r.root_id = id;
      req_backlog.push_back(r);
      n_queued++;
   endtask

   task automatic queue_random(input int wi, input int wd, input int wu, input int wl);
      int                r;
      action_type        a;
      logic [NAME_W-1:0] n;
      r = $urandom_range(wi + wd + wu + wl - 1);
      if (r < wi)                a = ACT_INSERT;
      else if (r < wi + wd)      a = ACT_DELETE;
      else if (r < wi + wd + wu) a = ACT_UPDATE;
      else                       a = ACT_LOOKUP;
      if ($urandom_range(9) == 0) n = noise_name();
      else n = pool_name($urandom_range(POOL_SIZE - 1), $urandom_range(1));
      queue_req(a, n, ID_W'($urandom));
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   // Hold until every queued word is accepted and answered
   task automatic wait_drained();
      while (n_accepted != n_queued || rsp_expected.size() != 0) @(negedge clock);
   endtask

   // Stream driver: offer queued words, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_expected.push_back(apply_request(cur_req));
            n_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = req_backlog.pop_front();
               req_tdata  <= pack_req(cur_req);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result ready: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
      end else if (hold_seen != hold_req) begin
         hold_seen  = hold_req;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result monitor: compare each word with the oldest prediction
   always @(posedge clock) begin
      table_rsp exp_rsp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_expected.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            exp_rsp = rsp_expected.pop_front();
            if (rsp_tdata[0 +: STATUS_W] != exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_rsp.status, rsp_tdata[0 +: STATUS_W]);
               fail_count++;
            end
            if (rsp_tdata[STATUS_W +: ID_W] != exp_rsp.found_id) begin
               $display("%0t: found_root_id expected %h actual %h", $time,
                        exp_rsp.found_id, rsp_tdata[STATUS_W +: ID_W]);
               fail_count++;
            end
            if (rsp_tdata[STATUS_W + ID_W +: ENTRY_CNT_W] != exp_rsp.count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        exp_rsp.count, rsp_tdata[STATUS_W + ID_W +: ENTRY_CNT_W]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else if (!reset) begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [NAME_W-1:0] name_a;
      logic [NAME_W-1:0] name_b;
      logic [NAME_W-1:0] name_e;
      int                pick;
      int                len;

      rec_count = 0; n_queued = 0; n_accepted = 0; fail_count = 0;
      hold_req = 0; hold_seen = 0; hold_left = 0; stuck_cycles = 0;
      set_idle(0, 0);

      // Name pool: random lengths, some near-twins differing in one byte
      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i > 0 && pool_len[i-1] > 0 && $urandom_range(3) == 0) begin
            name_pool[i] = name_pool[i-1];
            pool_len[i]  = pool_len[i-1];
            pick = $urandom_range(pool_len[i] - 1);
            name_pool[i][8*pick +: 8] = name_pool[i][8*pick +: 8] ^ 8'($urandom_range(255, 1));
            if (name_pool[i][8*pick +: 8] == 8'h00) name_pool[i][8*pick +: 8] = 8'h01;
         end else begin
            len = ($urandom_range(3) == 0) ? NAME_BYTES - 1 : $urandom_range(NAME_BYTES - 1);
            name_pool[i] = '0;
            pool_len[i]  = len;
            for (int b = 0; b < len; b++) name_pool[i][8*b +: 8] = 8'($urandom_range(255, 1));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty table, extremes, terminator handling, shifting delete
      name_a = '0;
      name_a[8*(NAME_BYTES-1)-1:0] = '1;
      name_b = '0;
      name_b[7:0] = 8'h42;
      name_b[8*(NAME_BYTES-1)-1:16] = '1;
      name_e = '0;
      name_e[8*(NAME_BYTES-1)-1:8] = '1;
      queue_req(ACT_DELETE, name_a, ID_MAX);
      queue_req(ACT_LOOKUP, name_a, '0);
      queue_req(ACT_UPDATE, name_a, ID_MAX);
      queue_req(ACT_INSERT, '0, ID_MAX);
      queue_req(ACT_INSERT, name_a, '0);
      queue_req(ACT_INSERT, name_a, ID_MAX);
      queue_req(ACT_INSERT, name_b, 31'h2AAA_AAAA);
      queue_req(ACT_INSERT, name_e, '0);
      queue_req(ACT_LOOKUP, {name_b[NAME_W-1:16] ^ {(NAME_W-16){1'b1}}, name_b[15:0]}, '0);
      queue_req(ACT_UPDATE, name_b, 31'h5555_5555);
      queue_req(ACT_LOOKUP, name_b, ID_MAX);
      queue_req(ACT_LOOKUP, name_e, '0);
      queue_req(ACT_LOOKUP, name_a, '0);
      queue_req(ACT_DELETE, name_a, '0);
      queue_req(ACT_LOOKUP, name_b, '0);
      queue_req(ACT_LOOKUP, '0, '0);
      queue_req(ACT_DELETE, '0, '0);
      queue_req(ACT_DELETE, name_b, '0);
      queue_req(ACT_LOOKUP, name_b, '0);
      queue_req(ACT_UPDATE, '0, ID_MAX);
      queue_req(ACT_DELETE, name_b, '0);
      wait_drained();

      // Fill to capacity, then full, duplicate-when-full and a front delete
      set_idle(0, 88);
      for (int i = 0; i < 70; i++) queue_req(ACT_INSERT, pool_name(i, 1'b1), ID_W'($urandom));
      queue_req(ACT_INSERT, pool_name(70, 1'b0), ID_MAX);
      queue_req(ACT_INSERT, pool_name(3, 1'b1), '0);
      queue_req(ACT_LOOKUP, pool_name(0, 1'b1), '0);
      queue_req(ACT_LOOKUP, pool_name(63, 1'b1), '0);
      queue_req(ACT_UPDATE, pool_name(30, 1'b0), ID_MAX);
      queue_req(ACT_LOOKUP, pool_name(30, 1'b1), '0);
      queue_req(ACT_DELETE, pool_name(0, 1'b0), '0);
      queue_req(ACT_INSERT, pool_name(70, 1'b1), ID_MAX);
      queue_req(ACT_LOOKUP, pool_name(70, 1'b0), '0);
      wait_drained();

      // Random traffic with no idling, then with the sender idling
      set_idle(0, 0);
      for (int i = 0; i < RAND_ITEMS; i++) queue_random(35, 20, 20, 25);
      wait_drained();
      set_idle(88, 0);
      for (int i = 0; i < RAND_ITEMS; i++) queue_random(35, 20, 20, 25);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering
      set_idle(0, 0);
      hold_req++;
      for (int i = 0; i < 40; i++) queue_random(30, 20, 20, 30);
      wait_drained();

      set_idle(0, 88);
      for (int i = 0; i < RAND_ITEMS; i++) queue_random(35, 20, 20, 25);
      wait_drained();
      set_idle(9, 9);
      for (int i = 0; i < RAND_ITEMS; i++) queue_random(35, 20, 20, 25);
      wait_drained();

      // Delete-heavy run to reach the empty table again
      set_idle(0, 0);
      for (int i = 0; i < RAND_ITEMS; i++) queue_random(15, 45, 20, 20);
      wait_drained();

      repeat (200) @(negedge clock);
      if (fail_count == 0 && rsp_expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/nkrt_pkg.sv
rtl/nkrt_store.sv
rtl/nkrt_seq.sv
rtl/name_keyed_record_table.sv
verif/tb_name_keyed_record_table.sv
